// ===== sv/vpic_pkg.sv =====
package vpic_pkg;

	localparam int DEF_NUM_SOURCES         = 64;
	localparam int DEF_NUM_PRIORITY_LEVELS = 16;

	localparam int WORD_W    = 64;
	localparam int HALF_W    = 32;
	localparam int PRI_W     = 4;
	localparam int VEC_W     = 32;
	localparam int VEC_DEPTH = 16;
	localparam int VEC_IDX_W = 4;
	localparam int REG_W     = 7;
	localparam int LINE_W    = 6;

	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 104;
	localparam int M_TUSER_W = 1;

	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_ASSERT = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// register map
	localparam logic [REG_W-1:0] REG_ENABLE_LO      = 7'd0;
	localparam logic [REG_W-1:0] REG_ENABLE_HI      = 7'd1;
	localparam logic [REG_W-1:0] REG_MASK_LO        = 7'd2;
	localparam logic [REG_W-1:0] REG_MASK_HI        = 7'd3;
	localparam logic [REG_W-1:0] REG_FORCE_LO       = 7'd4;
	localparam logic [REG_W-1:0] REG_FORCE_HI       = 7'd5;
	localparam logic [REG_W-1:0] REG_RAW_LO         = 7'd6;
	localparam logic [REG_W-1:0] REG_RAW_HI         = 7'd7;
	localparam logic [REG_W-1:0] REG_STATUS_LO      = 7'd8;
	localparam logic [REG_W-1:0] REG_STATUS_HI      = 7'd9;
	localparam logic [REG_W-1:0] REG_MASKED_LO      = 7'd10;
	localparam logic [REG_W-1:0] REG_MASKED_HI      = 7'd11;
	localparam logic [REG_W-1:0] REG_FINAL_LO       = 7'd12;
	localparam logic [REG_W-1:0] REG_FINAL_HI       = 7'd13;
	localparam logic [REG_W-1:0] REG_CUR_VECTOR     = 7'd14;
	localparam logic [REG_W-1:0] REG_THRESHOLD      = 7'd15;
	localparam logic [REG_W-1:0] REG_DEFAULT_VECTOR = 7'd16;
	localparam logic [REG_W-1:0] REG_VEC_BASE       = 7'd17;
	localparam logic [REG_W-1:0] REG_VEC_LAST       = 7'd32;
	localparam logic [REG_W-1:0] REG_PRI_BASE       = 7'd33;

	typedef struct packed {
		func_t               func;
		logic [REG_W-1:0]    reg_index;
		logic                wide_access;
		logic [WORD_W-1:0]   wdata;
		logic [LINE_W-1:0]   line_num;
	} item_t;

	// replace one 32-bit half of a word
	function automatic logic [WORD_W-1:0] set_half(input logic [WORD_W-1:0] old,
			input logic high, input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] v;
		v = old;
		if (high) begin
			v[WORD_W-1:HALF_W] = d[HALF_W-1:0];
		end else begin
			v[HALF_W-1:0] = d[HALF_W-1:0];
		end
		return v;
	endfunction

	// low nibble, clipped to the top level
	function automatic logic [PRI_W-1:0] sat_pri(input logic [PRI_W-1:0] v,
			input logic [PRI_W-1:0] top_level);
		return (v > top_level) ? top_level : v;
	endfunction

endpackage

// ===== sv/vectored_priority_interrupt_controller_unit.sv =====
// Vectored priority interrupt controller, up to 64 sources.
// Slave channel (s_*): one item per handshake; s_tuser carries the function
// (read, write, assert line, clear line), s_tdata the register number, access
// width, write data and source line number.
// Master channel (m_*): exactly one result item per input item, in order:
// read data, interrupt request and current vector in m_tdata, the unknown
// register flag in m_tuser.
// Pipeline: an item passes the input register, execute register and result
// register in that order before its result is offered.
// Throughput: one item per cycle while m_tready stays high. The state is written
// as the item leaves the input register; request and vector are formed from the
// updated state as the item leaves the execute register, before any later item
// can change it, through a parallel level compare and a 16-way priority encode.
// Reset: all masks, raw lines, threshold, vectors and priorities clear to zero,
// and all three stages empty.
// Stall: when m_tready is low the result register holds, the stages behind it
// fill up and s_tready drops once all three are full; nothing is lost.
module vectored_priority_interrupt_controller_unit #(
	parameter int NUM_SOURCES         = vpic_pkg::DEF_NUM_SOURCES,
	parameter int NUM_PRIORITY_LEVELS = vpic_pkg::DEF_NUM_PRIORITY_LEVELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [6:0] reg_index, [7] wide_access, [71:8] wdata, [77:72] line_num, [79:78] zero
	input  logic [vpic_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] func
	input  logic [vpic_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [63:0] rdata, [64] irq_out, [96:65] vector_out, [103:97] zero
	output logic [vpic_pkg::M_TDATA_W-1:0]   m_tdata,
	// [0] bad_register
	output logic [vpic_pkg::M_TUSER_W-1:0]   m_tuser
);

	localparam int NS     = NUM_SOURCES;
	localparam int PIDX_W = $clog2(NUM_SOURCES);
	localparam logic [vpic_pkg::REG_W:0] NS_CNT = (vpic_pkg::REG_W + 1)'(NUM_SOURCES);
	localparam logic [vpic_pkg::PRI_W-1:0] PRI_MAX =
		vpic_pkg::PRI_W'(NUM_PRIORITY_LEVELS - 1);

	// state
	logic [NS-1:0]                  enable_q, mask_q, force_q, raw_q;
	logic [vpic_pkg::PRI_W-1:0]     thr_q;
	logic [vpic_pkg::VEC_W-1:0]     default_q;
	logic [vpic_pkg::VEC_W-1:0]     vec_tab_q [vpic_pkg::VEC_DEPTH];
	logic [vpic_pkg::PRI_W-1:0]     pri_q [NS];

	// pipeline
	logic                           valid_s1, valid_s2, out_valid_q;
	vpic_pkg::item_t                item_s1;
	logic [vpic_pkg::WORD_W-1:0]    rdata_s2;
	logic                           bad_s2;
	logic [vpic_pkg::WORD_W-1:0]    out_rdata_q;
	logic                           out_bad_q, out_irq_q;
	logic [vpic_pkg::VEC_W-1:0]     out_vector_q;

	logic                           accept, adv_s1, adv_out;

	// status network
	logic [NS-1:0]                  status_w, masked_w, final_w;
	logic [NUM_PRIORITY_LEVELS-1:0] lvl_any;
	logic [vpic_pkg::PRI_W-1:0]     top_pri;
	logic [vpic_pkg::VEC_W-1:0]     cur_vector;
	logic                           irq_now;

	// decode of the item in the input register
	logic [vpic_pkg::REG_W-1:0]     vec_diff, pri_idx;
	logic [vpic_pkg::VEC_IDX_W-1:0] vec_idx;
	logic                           pri_hit, odd_reg;
	logic [vpic_pkg::WORD_W-1:0]    rd_word, rd_other, rdata_next;
	logic                           rd_is_word, rd_ok;
	logic [vpic_pkg::WORD_W-1:0]    word_old, word_new;
	logic [vpic_pkg::WORD_W-1:0]    line_dec64;
	logic [NS-1:0]                  line_dec;
	logic                           commit_wr;
	logic [vpic_pkg::PRI_W-1:0]     wr_pri;

	// handshake: each stage moves when the one ahead is empty or moving
	assign adv_out  = valid_s2 && (!out_valid_q || m_tready);
	assign adv_s1   = valid_s1 && (!valid_s2 || adv_out);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	// status words and the highest pending level
	assign status_w = (raw_q | force_q) & enable_q;
	assign masked_w = status_w & ~mask_q;

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			final_w[i] = masked_w[i] && (pri_q[i] >= thr_q);
		end
	end

	always_comb begin
		lvl_any = '0;
		for (int l = 0; l < NUM_PRIORITY_LEVELS; l++) begin
			for (int i = 0; i < NS; i++) begin
				if (final_w[i] && (pri_q[i] == vpic_pkg::PRI_W'(l))) begin
					lvl_any[l] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		top_pri = '0;
		for (int l = 0; l < NUM_PRIORITY_LEVELS; l++) begin
			if (lvl_any[l]) begin
				top_pri = vpic_pkg::PRI_W'(l);
			end
		end
	end

	assign irq_now    = |final_w;
	assign cur_vector = irq_now ? vec_tab_q[top_pri] : default_q;

	// register number decode
	assign odd_reg  = item_s1.reg_index[0];
	assign vec_diff = item_s1.reg_index - vpic_pkg::REG_VEC_BASE;
	assign vec_idx  = vec_diff[vpic_pkg::VEC_IDX_W-1:0];
	assign pri_idx  = item_s1.reg_index - vpic_pkg::REG_PRI_BASE;
	assign pri_hit  = (item_s1.reg_index >= vpic_pkg::REG_PRI_BASE) &&
		({1'b0, pri_idx} < NS_CNT);

	// read mux
	always_comb begin
		rd_word    = '0;
		rd_other   = '0;
		rd_is_word = 1'b0;
		rd_ok      = 1'b1;
		unique case (item_s1.reg_index) inside
			vpic_pkg::REG_ENABLE_LO, vpic_pkg::REG_ENABLE_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(enable_q);
			end
			vpic_pkg::REG_MASK_LO, vpic_pkg::REG_MASK_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(mask_q);
			end
			vpic_pkg::REG_FORCE_LO, vpic_pkg::REG_FORCE_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(force_q);
			end
			vpic_pkg::REG_RAW_LO, vpic_pkg::REG_RAW_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(raw_q);
			end
			vpic_pkg::REG_STATUS_LO, vpic_pkg::REG_STATUS_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(status_w);
			end
			vpic_pkg::REG_MASKED_LO, vpic_pkg::REG_MASKED_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(masked_w);
			end
			vpic_pkg::REG_FINAL_LO, vpic_pkg::REG_FINAL_HI: begin
				rd_is_word = 1'b1;
				rd_word    = vpic_pkg::WORD_W'(final_w);
			end
			vpic_pkg::REG_CUR_VECTOR: begin
				rd_other = vpic_pkg::WORD_W'(cur_vector);
			end
			vpic_pkg::REG_THRESHOLD: begin
				rd_other = vpic_pkg::WORD_W'(thr_q);
			end
			vpic_pkg::REG_DEFAULT_VECTOR: begin
				rd_other = vpic_pkg::WORD_W'(default_q);
			end
			[vpic_pkg::REG_VEC_BASE:vpic_pkg::REG_VEC_LAST]: begin
				rd_other = vpic_pkg::WORD_W'(vec_tab_q[vec_idx]);
			end
			default: begin
				if (pri_hit) begin
					rd_other = vpic_pkg::WORD_W'(pri_q[pri_idx[PIDX_W-1:0]]);
				end else begin
					rd_ok = 1'b0;
				end
			end
		endcase

		if (!rd_is_word) begin
			rdata_next = rd_other;
		end else if (odd_reg) begin
			rdata_next = {{vpic_pkg::HALF_W{1'b0}}, rd_word[vpic_pkg::WORD_W-1:vpic_pkg::HALF_W]};
		end else if (item_s1.wide_access) begin
			rdata_next = rd_word;
		end else begin
			rdata_next = {{vpic_pkg::HALF_W{1'b0}}, rd_word[vpic_pkg::HALF_W-1:0]};
		end
	end

	// new value for a write to one of the writable mask words
	always_comb begin
		unique case (item_s1.reg_index) inside
			vpic_pkg::REG_ENABLE_LO, vpic_pkg::REG_ENABLE_HI:
				word_old = vpic_pkg::WORD_W'(enable_q);
			vpic_pkg::REG_MASK_LO, vpic_pkg::REG_MASK_HI:
				word_old = vpic_pkg::WORD_W'(mask_q);
			default:
				word_old = vpic_pkg::WORD_W'(force_q);
		endcase
		if (!odd_reg && item_s1.wide_access) begin
			word_new = item_s1.wdata;
		end else begin
			word_new = vpic_pkg::set_half(word_old, odd_reg, item_s1.wdata);
		end
	end

	// one-hot line select; lines beyond the source count fall off the top
	assign line_dec64 = vpic_pkg::WORD_W'(1) << item_s1.line_num;
	assign line_dec   = line_dec64[NS-1:0];

	assign commit_wr = adv_s1 && (item_s1.func == vpic_pkg::FUNC_WRITE);
	assign wr_pri    = vpic_pkg::sat_pri(item_s1.wdata[vpic_pkg::PRI_W-1:0], PRI_MAX);

	// state update as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= '0;
			mask_q    <= '0;
			force_q   <= '0;
			raw_q     <= '0;
			thr_q     <= '0;
			default_q <= '0;
			for (int i = 0; i < vpic_pkg::VEC_DEPTH; i++) begin
				vec_tab_q[i] <= '0;
			end
			for (int i = 0; i < NS; i++) begin
				pri_q[i] <= '0;
			end
		end else begin
			if (adv_s1 && (item_s1.func == vpic_pkg::FUNC_ASSERT)) begin
				raw_q <= raw_q | line_dec;
			end
			if (adv_s1 && (item_s1.func == vpic_pkg::FUNC_CLEAR)) begin
				raw_q <= raw_q & ~line_dec;
			end
			if (commit_wr) begin
				unique case (item_s1.reg_index) inside
					vpic_pkg::REG_ENABLE_LO, vpic_pkg::REG_ENABLE_HI: begin
						enable_q <= word_new[NS-1:0];
					end
					vpic_pkg::REG_MASK_LO, vpic_pkg::REG_MASK_HI: begin
						mask_q <= word_new[NS-1:0];
					end
					vpic_pkg::REG_FORCE_LO, vpic_pkg::REG_FORCE_HI: begin
						force_q <= word_new[NS-1:0];
					end
					vpic_pkg::REG_THRESHOLD: begin
						thr_q <= wr_pri;
					end
					vpic_pkg::REG_DEFAULT_VECTOR: begin
						default_q <= item_s1.wdata[vpic_pkg::VEC_W-1:0];
					end
					[vpic_pkg::REG_VEC_BASE:vpic_pkg::REG_VEC_LAST]: begin
						vec_tab_q[vec_idx] <= item_s1.wdata[vpic_pkg::VEC_W-1:0];
					end
					default: begin
						// read-only and unknown registers drop the write
						if (pri_hit) begin
							pri_q[pri_idx[PIDX_W-1:0]] <= wr_pri;
						end
					end
				endcase
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_out) begin
				valid_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func        <= vpic_pkg::func_t'(s_tuser[1:0]);
			item_s1.reg_index   <= s_tdata[6:0];
			item_s1.wide_access <= s_tdata[7];
			item_s1.wdata       <= s_tdata[71:8];
			item_s1.line_num    <= s_tdata[77:72];
		end
		if (adv_s1) begin
			rdata_s2 <= (item_s1.func == vpic_pkg::FUNC_READ) ? rdata_next : '0;
			bad_s2   <= (item_s1.func == vpic_pkg::FUNC_READ) && !rd_ok;
		end
		// state now holds exactly what the item in s2 left behind
		if (adv_out) begin
			out_rdata_q  <= rdata_s2;
			out_bad_q    <= bad_s2;
			out_irq_q    <= irq_now;
			out_vector_q <= cur_vector;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_vector_q, out_irq_q, out_rdata_q};
	assign m_tuser  = out_bad_q;

endmodule
